FILE: src/acmac_pkg.sv
// constants and helper functions for the aes cmac engine
// used by aes_cmac_engine; no dependencies
package acmac_pkg;

   localparam logic [7:0] CMAC_RB  = 8'h87;
   localparam logic [7:0] CMAC_PAD = 8'h80;
   localparam logic [4:0] CMAC_BLOCK = 5'd16;

   localparam logic [1:0] KEY_128 = 2'd0;
   localparam logic [1:0] KEY_192 = 2'd1;

   localparam logic [2:0] CSR_KEY0 = 3'd0;
   localparam logic [2:0] CSR_KEY1 = 3'd1;
   localparam logic [2:0] CSR_KEY2 = 3'd2;
   localparam logic [2:0] CSR_KEY3 = 3'd3;
   localparam logic [2:0] CSR_MODE = 3'd4;

   localparam logic [7:0] SBOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   function automatic logic [7:0] xtime(input logic [7:0] v);
      xtime = {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [31:0] sub_word(input logic [31:0] w);
      sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
   endfunction

   // one aes round without addroundkey: subbytes, shiftrows, optional mixcolumns
   function automatic logic [127:0] aes_round(input logic [127:0] s, input logic mix);
      logic [7:0] b [16];
      logic [7:0] t [16];
      logic [7:0] a0, a1, a2, a3, all;
      logic [127:0] r;
      for (int j = 0; j < 16; j++) b[j] = s[127 - 8*j -: 8];
      for (int c = 0; c < 4; c++)
         for (int j = 0; j < 4; j++) t[c*4 + j] = SBOX[b[((c + j) % 4)*4 + j]];
      if (mix) begin
         for (int c = 0; c < 4; c++) begin
            a0 = t[c*4]; a1 = t[c*4+1]; a2 = t[c*4+2]; a3 = t[c*4+3];
            all = a0 ^ a1 ^ a2 ^ a3;
            t[c*4]   = a0 ^ all ^ xtime(a0 ^ a1);
            t[c*4+1] = a1 ^ all ^ xtime(a1 ^ a2);
            t[c*4+2] = a2 ^ all ^ xtime(a2 ^ a3);
            t[c*4+3] = a3 ^ all ^ xtime(a3 ^ a0);
         end
      end
      for (int j = 0; j < 16; j++) r[127 - 8*j -: 8] = t[j];
      aes_round = r;
   endfunction

   function automatic logic [127:0] gf_dbl128(input logic [127:0] a);
      gf_dbl128 = {a[126:0], 1'b0} ^ {120'd0, (a[127] ? CMAC_RB : 8'h00)};
   endfunction

endpackage

FILE: src/aes_cmac_engine.sv
// Each 16-byte beat runs one AES encryption on a shared round unit. The key schedule
// produces one 32-bit word per cycle while not held, and a round is applied each time
// four words complete a round key, with 128/192/256-bit keys. A new beat is taken
// only when the engine is idle, after the previous beat is finished. The first beat
// of a message first encrypts zero for the subkeys K1/K2, which doubles its work.
// The tag is registered when the final round of the last beat completes.
// The tag is held in an output register, and request beats keep being taken while it
// waits. A beat that would produce a new tag holds in its final round until the
// waiting tag is taken.
// Depends on acmac_pkg.
module aes_cmac_engine import acmac_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [63:0] req_block_high,
   input  logic [63:0] req_block_low,
   input  logic [4:0]  req_valid_bytes,
   input  logic        req_last_block,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_tag_high,
   output logic [63:0] rsp_tag_low,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_data
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_LOAD = 2'd1;
   localparam logic [1:0] ST_RUN  = 2'd2;

   logic [255:0] key_ff;
   logic [1:0]   mode_ff;
   logic [1:0]   st_ff, st_in;
   logic [127:0] state_ff, state_in;
   logic [127:0] chain_ff, chain_in;
   logic [127:0] k1_ff, k1_in, k2_ff, k2_in;
   logic [127:0] blk_ff, blk_in;
   logic         last_ff, last_in;
   logic         sub_ff, sub_in;
   logic         inmsg_ff, inmsg_in;
   logic [255:0] win_ff, win_in;     // sliding window of the last nk words
   logic [127:0] rk_ff, rk_in;       // round key being assembled
   logic [5:0]   wi_ff, wi_in;       // schedule word index
   logic [7:0]   rcon_ff, rcon_in;
   logic [2:0]   kc_ff, kc_in;       // word position mod nk
   logic [1:0]   col_ff, col_in;     // word position within round key
   logic [3:0]   rnd_ff, rnd_in;
   logic         ov_ff, ov_in;
   logic [127:0] tag_ff, tag_in;
   logic         blk_sel_full_ff, blk_sel_full_in;

   logic [3:0]   nk, nr;
   logic [31:0]  prev_w, old_w, tmp_w, new_w;
   logic [127:0] blk_c, pad_blk, mask;
   logic [4:0]   vb;
   logic         accept, rk_done, hold;

   always_comb begin
      nk = (mode_ff == KEY_128) ? 4'd4 : (mode_ff == KEY_192) ? 4'd6 : 4'd8;
      nr = nk + 4'd6;
   end

   assign req_stall    = (st_ff != ST_IDLE);
   assign accept       = req_valid && !req_stall;
   assign rsp_valid    = ov_ff;
   assign rsp_tag_high = tag_ff[127:64];
   assign rsp_tag_low  = tag_ff[63:0];

   // key schedule word step
   always_comb begin
      prev_w = win_ff[31:0];
      case (nk)
         4'd4:    old_w = win_ff[127:96];
         4'd6:    old_w = win_ff[191:160];
         default: old_w = win_ff[255:224];
      endcase
      if (kc_ff == 3'd0)
         tmp_w = sub_word({prev_w[23:0], prev_w[31:24]}) ^ {rcon_ff, 24'd0};
      else if (nk == 4'd8 && kc_ff == 3'd4)
         tmp_w = sub_word(prev_w);
      else
         tmp_w = prev_w;
      new_w = (wi_ff < {2'd0, nk}) ? key_ff[255 - 32*wi_ff[2:0] -: 32] : old_w ^ tmp_w;
   end

   always_comb begin
      vb = (req_valid_bytes > CMAC_BLOCK) ? CMAC_BLOCK : req_valid_bytes;
      mask = ~(128'h0) << {vb == CMAC_BLOCK ? 8'd0 : (8'd128 - {vb, 3'b000})};
      if (vb == CMAC_BLOCK) mask = '1;
      pad_blk = ({req_block_high, req_block_low} & mask)
              | ({CMAC_PAD, 120'd0} >> {vb, 3'b000});
      blk_c = {req_block_high, req_block_low};
   end

   assign rk_done = (col_ff == 2'd3);

   // tag beat finishing while the previous tag still waits
   assign hold = rk_done && (rnd_ff == nr) && !sub_ff && last_ff && ov_ff && rsp_stall;

   function automatic logic [127:0] state_ff_input();
      logic [127:0] x;
      x = blk_ff ^ chain_ff;
      if (last_ff) begin
         if (blk_sel_full_ff) x = x ^ k1_ff;
         else x = x ^ k2_ff;
      end
      state_ff_input = x;
   endfunction

   always_comb begin
      st_in = st_ff; state_in = state_ff; chain_in = chain_ff;
      k1_in = k1_ff; k2_in = k2_ff; blk_in = blk_ff; last_in = last_ff;
      sub_in = sub_ff; inmsg_in = inmsg_ff; win_in = win_ff; rk_in = rk_ff;
      wi_in = wi_ff; rcon_in = rcon_ff; kc_in = kc_ff; col_in = col_ff;
      rnd_in = rnd_ff; ov_in = ov_ff && rsp_stall; tag_in = tag_ff;
      case (st_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_last_block) blk_in = (vb == CMAC_BLOCK) ? blk_c : pad_blk;
               else blk_in = blk_c;
               last_in = req_last_block;
               sub_in = !inmsg_ff;
               if (!inmsg_ff) chain_in = '0;
               inmsg_in = 1'b1;
               st_in = ST_LOAD;
               wi_in = '0; kc_in = '0; col_in = '0; rnd_in = '0; rcon_in = 8'h01;
               win_in = '0;
               // cleared here; cipher input with final xor with k1/k2 is loaded at round 0
               state_in = '0;
            end
         end
         ST_LOAD, ST_RUN: begin
            if (!hold) begin
               // one schedule word per cycle, round applied when a round key completes
               win_in = {win_ff[223:0], new_w};
               rk_in = {rk_ff[95:0], new_w};
               wi_in = wi_ff + 6'd1;
               col_in = col_ff + 2'd1;
               kc_in = (kc_ff == nk[2:0] - 3'd1) ? 3'd0 : kc_ff + 3'd1;
               if (nk == 4'd8 && kc_ff == 3'd7) kc_in = 3'd0;
               if (wi_ff >= {2'd0, nk} && kc_ff == 3'd0) rcon_in = xtime(rcon_ff);
               if (rk_done) begin
                  if (rnd_ff == 4'd0) begin
                     state_in = (sub_ff ? 128'd0 : state_ff_input()) ^ {rk_ff[95:0], new_w};
                     st_in = ST_RUN;
                  end else begin
                     state_in = aes_round(state_ff, rnd_ff != nr) ^ {rk_ff[95:0], new_w};
                  end
                  rnd_in = rnd_ff + 4'd1;
                  if (rnd_ff == nr) begin
                     if (sub_ff) begin
                        k1_in = gf_dbl128(state_in);
                        k2_in = gf_dbl128(gf_dbl128(state_in));
                        sub_in = 1'b0;
                        wi_in = '0; kc_in = '0; col_in = '0; rnd_in = '0; rcon_in = 8'h01;
                        st_in = ST_LOAD;
                     end else begin
                        chain_in = state_in;
                        st_in = ST_IDLE;
                        if (last_ff) begin
                           inmsg_in = 1'b0;
                           ov_in = 1'b1;
                           tag_in = state_in;
                        end
                     end
                  end
               end
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   assign blk_sel_full_in = accept ? (vb == CMAC_BLOCK) : blk_sel_full_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
         mode_ff <= KEY_128;
         st_ff <= ST_IDLE;
         inmsg_ff <= 1'b0;
         ov_ff <= 1'b0;
         chain_ff <= '0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_KEY0: key_ff[255:192] <= csr_data;
               CSR_KEY1: key_ff[191:128] <= csr_data;
               CSR_KEY2: key_ff[127:64]  <= csr_data;
               CSR_KEY3: key_ff[63:0]    <= csr_data;
               CSR_MODE: mode_ff <= csr_data[1:0];
               default: ;
            endcase
         end
         st_ff <= st_in;
         inmsg_ff <= inmsg_in;
         ov_ff <= ov_in;
         chain_ff <= chain_in;
      end
      state_ff <= state_in; k1_ff <= k1_in; k2_ff <= k2_in; blk_ff <= blk_in;
      last_ff <= last_in; sub_ff <= sub_in; win_ff <= win_in; rk_ff <= rk_in;
      wi_ff <= wi_in; rcon_ff <= rcon_in; kc_ff <= kc_in; col_ff <= col_in;
      rnd_ff <= rnd_in; tag_ff <= tag_in; blk_sel_full_ff <= blk_sel_full_in;
   end

endmodule
